@@ hw/rtl/assert_macros.svh @@
// Concurrent assertion helpers, clocked on the rising edge, off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mfr_pkg.sv @@
package mfr_pkg;

    localparam int MFR_MAX_DATA_LEN = 16;
    localparam int FRAME_OVERHEAD   = 12;

    localparam logic [7:0] START_BYTE  = 8'h68;
    localparam logic [7:0] DATA_OFFSET = 8'h33;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_METER_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ADDR = 2'd1;

    typedef enum logic [1:0] {
        FS_GOOD     = 2'd0,
        FS_BAD_SUM  = 2'd1,
        FS_TOO_LONG = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic take_byte;
        logic emit_load;
    } mfr_cmd_t;

    typedef struct packed {
        logic out_free;
        logic emit_pos;
        logic start_data;
        logic emit_last;
    } mfr_sts_t;

    function automatic logic [4:0] sat_len(input logic [7:0] l);
        return (l > 8'd31) ? 5'd31 : l[4:0];
    endfunction

endpackage

@@ hw/rtl/meter_frame_receiver_unit.sv @@
// Byte-serial receiver for meter response frames. Bytes enter one per beat on s_*; the
// unit hunts for the 0x68 start byte (skipping any preamble), checks the second 0x68 and,
// if check_address is set, the six address bytes against meter_address, then buffers up to
// MAX_DATA_LEN data bytes and a mod-256 checksum. When the end byte arrives, a good frame
// is sent on m_* as one beat per data byte (0x33 removed, tlast on the final one); a bad
// checksum, a length above MAX_DATA_LEN or a good frame of no data gives one status beat.
// While a frame is being received a byte is taken every cycle; s_tready drops at the
// length and end byte positions only while a result beat is still waiting on m_*. After
// a good frame with data, each burst beat is a registered read of the data buffer, then
// the output register load, held while a beat waits on m_*; s_tready is low for the burst.
module meter_frame_receiver_unit
    import mfr_pkg::*;
#(
    parameter int MAX_DATA_LEN = MFR_MAX_DATA_LEN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]          cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [7:0] control_code, [12:8] data_len,
                                            // [16:13] byte_index, [24:17] data_byte
    output logic [1:0]           m_tuser,   // [1:0] frame_status
    output logic                 m_tlast    // last
);

    mfr_cmd_t cmd;
    mfr_sts_t sts;

    assign cfg_ready = 1'b1;

    mfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mfr_dp #(
        .MAX_DATA_LEN (MAX_DATA_LEN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ hw/rtl/mfr_ctrl.sv @@
`include "assert_macros.svh"

module mfr_ctrl
    import mfr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  mfr_sts_t sts,
    output mfr_cmd_t cmd
);

    typedef enum logic [2:0] {
        CS_RX = 3'b001,
        CS_RD = 3'b010,
        CS_LD = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        in_ok;

    assign in_ok    = sts.out_free || !sts.emit_pos;
    assign s_tready = (state_reg == CS_RX) && in_ok;

    always_comb begin
        state_next    = state_reg;
        cmd.take_byte = 1'b0;
        cmd.emit_load = 1'b0;
        unique case (state_reg)
            CS_RX: begin
                cmd.take_byte = s_tvalid && in_ok;
                if (cmd.take_byte && sts.start_data) begin
                    state_next = CS_RD;
                end
            end
            CS_RD: begin
                state_next = CS_LD;
            end
            CS_LD: begin
                if (sts.out_free) begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.emit_last ? CS_RX : CS_RD;
                end
            end
            default: begin
                state_next = CS_RX;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_RX;
        end else begin
            state_reg <= state_next;
        end
    end

    `ASSERT_IMPLY(a_load_free, aclk, aresetn, cmd.emit_load, sts.out_free, "emit into busy output")
    `ASSERT_IMPLY(a_rd_entry, aclk, aresetn, state_reg == CS_RD && $past(state_reg == CS_RX),
        $past(cmd.take_byte && sts.start_data), "burst started without good frame")
    `ASSERT_IMPLY(a_no_take_burst, aclk, aresetn, state_reg != CS_RX, !s_tready,
        "byte taken during burst")

endmodule

@@ hw/rtl/mfr_dp.sv @@
`include "assert_macros.svh"

module mfr_dp
    import mfr_pkg::*;
#(
    parameter int MAX_DATA_LEN = MFR_MAX_DATA_LEN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]          cfg_data,
    input  logic [7:0]           s_tdata,
    input  mfr_cmd_t             cmd,
    output mfr_sts_t             sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int AW = (MAX_DATA_LEN > 1) ? $clog2(MAX_DATA_LEN) : 1;
    localparam int CW = $clog2(MAX_DATA_LEN + FRAME_OVERHEAD);
    localparam logic [8:0]    MAX_LEN9   = 9'(MAX_DATA_LEN);
    localparam logic [CW-1:0] POS_ADDR_LO = CW'(1);
    localparam logic [CW-1:0] POS_ADDR_HI = CW'(6);
    localparam logic [CW-1:0] POS_START2  = CW'(7);
    localparam logic [CW-1:0] POS_CTRL    = CW'(8);
    localparam logic [CW-1:0] POS_LEN     = CW'(9);
    localparam logic [CW-1:0] POS_DATA    = CW'(10);

    logic [47:0]   meter_addr_reg;
    logic          chk_addr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    sum_reg, sum_next;
    logic          addr_ok_reg, addr_ok_next;
    logic [7:0]    ctrl_reg;
    logic [7:0]    len_reg;
    logic [7:0]    cks_reg;
    logic [7:0]    mem [MAX_DATA_LEN];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] emit_idx_reg;

    logic          out_vld_reg;
    frame_status_t out_status_reg;
    logic [7:0]    out_ctrl_reg;
    logic [4:0]    out_len_reg;
    logic [3:0]    out_idx_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    logic [CW-1:0] len_cw, data_end;
    logic [7:0]    want;
    logic          is_hunt, is_addr, is_start2, is_ctrl, is_len, is_data, is_cks, is_end;
    logic          too_long, sum_ok;
    logic          st_load, wr_en;
    frame_status_t st_code;
    logic [4:0]    st_len;

    assign len_cw    = CW'(len_reg);
    assign data_end  = POS_DATA + len_cw;
    assign is_hunt   = cnt_reg == '0;
    assign is_addr   = cnt_reg >= POS_ADDR_LO && cnt_reg <= POS_ADDR_HI;
    assign is_start2 = cnt_reg == POS_START2;
    assign is_ctrl   = cnt_reg == POS_CTRL;
    assign is_len    = cnt_reg == POS_LEN;
    assign is_data   = cnt_reg >= POS_DATA && cnt_reg < data_end;
    assign is_cks    = cnt_reg >= POS_DATA && cnt_reg == data_end;
    assign is_end    = cnt_reg >= POS_DATA && cnt_reg == data_end + CW'(1);
    assign too_long  = {1'b0, s_tdata} > MAX_LEN9;
    assign sum_ok    = sum_reg == cks_reg;

    always_comb begin
        unique case (cnt_reg[2:0])
            3'd1:    want = meter_addr_reg[7:0];
            3'd2:    want = meter_addr_reg[15:8];
            3'd3:    want = meter_addr_reg[23:16];
            3'd4:    want = meter_addr_reg[31:24];
            3'd5:    want = meter_addr_reg[39:32];
            3'd6:    want = meter_addr_reg[47:40];
            default: want = 8'h00;
        endcase
    end

    assign sts.out_free   = !out_vld_reg || m_tready;
    assign sts.emit_pos   = is_len || is_end;
    assign sts.start_data = is_end && sum_ok && (len_reg != 8'd0);
    assign sts.emit_last  = (CW'(emit_idx_reg) + CW'(1)) == len_cw;

    always_comb begin
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        addr_ok_next = addr_ok_reg;
        st_load      = 1'b0;
        st_code      = FS_GOOD;
        st_len       = sat_len(len_reg);
        wr_en        = 1'b0;
        if (cmd.take_byte) begin
            if (is_hunt) begin
                if (s_tdata == START_BYTE) begin
                    cnt_next     = POS_ADDR_LO;
                    sum_next     = START_BYTE;
                    addr_ok_next = 1'b1;
                end
            end else if (is_addr) begin
                if (s_tdata != want) begin
                    addr_ok_next = 1'b0;
                end
                sum_next = sum_reg + s_tdata;
                cnt_next = cnt_reg + CW'(1);
            end else if (is_start2) begin
                if (s_tdata != START_BYTE || (chk_addr_reg && !addr_ok_reg)) begin
                    cnt_next     = '0;
                    sum_next     = 8'h00;
                    addr_ok_next = 1'b1;
                end else begin
                    sum_next = sum_reg + s_tdata;
                    cnt_next = cnt_reg + CW'(1);
                end
            end else if (is_ctrl) begin
                sum_next = sum_reg + s_tdata;
                cnt_next = cnt_reg + CW'(1);
            end else if (is_len) begin
                if (too_long) begin
                    st_load      = 1'b1;
                    st_code      = FS_TOO_LONG;
                    st_len       = sat_len(s_tdata);
                    cnt_next     = '0;
                    sum_next     = 8'h00;
                    addr_ok_next = 1'b1;
                end else begin
                    sum_next = sum_reg + s_tdata;
                    cnt_next = cnt_reg + CW'(1);
                end
            end else if (is_data) begin
                wr_en    = 1'b1;
                sum_next = sum_reg + s_tdata;
                cnt_next = cnt_reg + CW'(1);
            end else if (is_cks) begin
                cnt_next = cnt_reg + CW'(1);
            end else begin
                // end byte: judge the frame
                cnt_next     = '0;
                sum_next     = 8'h00;
                addr_ok_next = 1'b1;
                if (!sum_ok) begin
                    st_load = 1'b1;
                    st_code = FS_BAD_SUM;
                end else if (len_reg == 8'd0) begin
                    st_load = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meter_addr_reg <= '0;
            chk_addr_reg   <= 1'b1;
            cnt_reg        <= '0;
            sum_reg        <= 8'h00;
            addr_ok_reg    <= 1'b1;
            out_vld_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_METER_ADDR: meter_addr_reg <= cfg_data;
                    CFG_CHECK_ADDR: chk_addr_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            addr_ok_reg <= addr_ok_next;
            if (st_load || cmd.emit_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_byte && is_ctrl) begin
            ctrl_reg <= s_tdata;
        end
        if (cmd.take_byte && is_len) begin
            len_reg <= s_tdata;
        end
        if (cmd.take_byte && is_cks) begin
            cks_reg <= s_tdata;
        end
        if (wr_en) begin
            mem[AW'(cnt_reg - POS_DATA)] <= s_tdata;
        end
        rd_data_reg <= mem[emit_idx_reg];
        if (cmd.take_byte && sts.start_data) begin
            emit_idx_reg <= '0;
        end else if (cmd.emit_load) begin
            emit_idx_reg <= emit_idx_reg + AW'(1);
        end
        if (st_load) begin
            out_status_reg <= st_code;
            out_ctrl_reg   <= ctrl_reg;
            out_len_reg    <= st_len;
            out_idx_reg    <= 4'd0;
            out_byte_reg   <= 8'h00;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit_load) begin
            out_status_reg <= FS_GOOD;
            out_ctrl_reg   <= ctrl_reg;
            out_len_reg    <= sat_len(len_reg);
            out_idx_reg    <= 4'(emit_idx_reg);
            out_byte_reg   <= rd_data_reg - DATA_OFFSET;
            out_last_reg   <= sts.emit_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_byte_reg, out_idx_reg, out_len_reg, out_ctrl_reg};

    `ASSERT_IMPLY(a_status_last, aclk, aresetn, out_vld_reg && out_status_reg != FS_GOOD,
        out_last_reg && out_idx_reg == 4'd0 && out_byte_reg == 8'h00, "bad status item")
    `ASSERT_ALWAYS(a_one_load, aclk, aresetn, !(st_load && cmd.emit_load),
        "status and data load together")
    `ASSERT_IMPLY(a_out_hold, aclk, aresetn, out_vld_reg && !m_tready,
        !(st_load || cmd.emit_load), "waiting beat overwritten")

endmodule
